// ===== sv/svpwm_pkg.sv =====
// Shared types, constants and tables for the space-vector PWM duty unit.
`timescale 1ns / 1ps
package svpwm_pkg;

  // Angle resolution in bits (one turn) and duty resolution in bits.
  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 16;

  // Rotation datapath.
  localparam int XY_W            = 32;
  localparam int Z_W             = 32;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  // Normalisation and division.
  localparam int NORM_STAGES = 6;
  localparam int QUO_W       = 33;
  localparam int DIV_STAGES  = QUO_W;
  localparam int NUM_W       = 64;
  localparam int DEN_W       = 32;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // (1.5 / K) * 2^30 and (sqrt3 / 2 / K) * 2^30, K being the rotation gain.
  localparam logic signed [31:0] COEF_H = 32'sd978049311;
  localparam logic signed [31:0] COEF_G = 32'sd564677033;

  // Register map.
  localparam logic       REG_SUPPLY   = 1'b0;
  localparam logic [15:0] SUPPLY_RESET = 16'd3072;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic [2:0]             sector_t;

  localparam sector_t SEC_1 = 3'd1;
  localparam sector_t SEC_2 = 3'd2;
  localparam sector_t SEC_3 = 3'd3;
  localparam sector_t SEC_4 = 3'd4;
  localparam sector_t SEC_5 = 3'd5;
  localparam sector_t SEC_6 = 3'd6;

  // Vector and residual angle carried through the rotation stages.
  typedef struct packed {
    xy_t                   x;
    xy_t                   y;
    logic signed [Z_W-1:0] z;
  } cordic_t;

endpackage

// ===== sv/space_vector_pwm_duty_unit.sv =====
// Space-vector PWM duty unit: d/q command and rotor angle in, three centred phase duties out.
// The unit takes one transaction per clock and returns one result transaction for each, in
// order, after it has passed through one input stage, twelve rotation stages (two
// iterations each), three sector and numerator stages, an overmodulation test, six
// normalisation stages and a divider set-up stage, a 33-stage bit-per-stage divider, a
// time-sum stage and the output register. The whole pipeline advances together and holds
// while a result waits on the output side. The supply voltage register at byte address 0
// may be written only while no transaction is in flight.
`timescale 1ns / 1ps
module space_vector_pwm_duty_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream; tdata: uq_voltage[15:0], ud_voltage[31:16], rotor_angle[47:32].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // Output stream; tdata: duty_phase_a[15:0], duty_phase_b[31:16], duty_phase_c[47:32],
  // vector_sector[50:48], overmodulated[51], zero[55:52].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svpwm_pkg::*;

  localparam logic [33:0] ONE_T    = 34'h1_0000_0000;
  localparam logic [34:0] DUTY_MAX = (35'd1 << DUTY_BITS) - 35'd1;
  localparam logic [34:0] DUTY_RND = 35'd1 << (31 - DUTY_BITS);
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // Time fraction to rounded, saturated duty.
  function automatic logic [15:0] to_duty(input logic [33:0] t);
    logic [34:0] d;
    d = ({1'b0, t} + DUTY_RND) >> (32 - DUTY_BITS);
    if (d > DUTY_MAX) begin
      d = DUTY_MAX;
    end
    return d[15:0];
  endfunction

  // Configuration register.
  logic [15:0] supply_q;
  logic [15:0] vs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SUPPLY)) begin
      supply_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SUPPLY) ? {16'b0, supply_q} : 32'b0;
  assign vs     = (supply_q == 16'd0) ? 16'd1 : supply_q;

  // Global advance: every stage moves unless a result is held at the output.
  logic out_vld_q;
  logic en;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage: quadrant pre-rotation and initial residual angle.
  logic signed [15:0] uq;
  logic signed [15:0] ud;
  logic [31:0]        ang_m;
  logic [31:0]        pa;
  logic [1:0]         quad;
  logic [31:0]        dres;
  xy_t                x0;
  xy_t                y0;
  cordic_t            vec_d;
  cordic_t            vec_q;
  logic [15:0]        ang_q;
  logic               in_vld_q;

  assign uq    = s_axis_tdata[15:0];
  assign ud    = s_axis_tdata[31:16];
  assign ang_m = 32'(s_axis_tdata[47:32]) & ANG_MASK;
  assign pa    = ang_m << (32 - ANGLE_BITS);
  assign quad  = 2'((pa + 32'h2000_0000) >> 30);
  assign dres  = pa - {quad, 30'b0};
  assign x0    = XY_W'(ud) <<< 12;
  assign y0    = XY_W'(uq) <<< 12;

  always_comb begin
    vec_d.z = dres;
    case (quad)
      2'd1: begin
        vec_d.x = -y0;
        vec_d.y = x0;
      end
      2'd2: begin
        vec_d.x = -x0;
        vec_d.y = -y0;
      end
      2'd3: begin
        vec_d.x = y0;
        vec_d.y = -x0;
      end
      default: begin
        vec_d.x = x0;
        vec_d.y = y0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q <= vec_d;
      ang_q <= ang_m[15:0];
    end
  end

  // Rotation and sector stages.
  logic        rot_vld;
  cordic_t     rot_vec;
  logic [15:0] rot_ang;
  logic        sc_vld;
  sector_t     sc_sec;
  logic [63:0] sc_n1;
  logic [63:0] sc_n2;

  svpwm_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_vld_q),
    .vec_i  (vec_q),
    .ang_i  (ang_q),
    .vld_o  (rot_vld),
    .vec_o  (rot_vec),
    .ang_o  (rot_ang)
  );

  svpwm_sect u_sect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (rot_vld),
    .x_i      (rot_vec.x),
    .y_i      (rot_vec.y),
    .ang_i    (rot_ang),
    .vld_o    (sc_vld),
    .sector_o (sc_sec),
    .n1_o     (sc_n1),
    .n2_o     (sc_n2)
  );

  // Overmodulation test: T1 + T2 above one.
  logic [64:0] nsum;
  logic        ov_vld_q;
  logic        ov_q;
  sector_t     ov_sec_q;
  logic [63:0] ov_a_q;
  logic [63:0] ov_b_q;

  assign nsum = {1'b0, sc_n1} + {1'b0, sc_n2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_vld_q <= 1'b0;
    end else if (en) begin
      ov_vld_q <= sc_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ov_q     <= nsum > {7'b0, vs, 42'b0};
      ov_sec_q <= sc_sec;
      ov_a_q   <= sc_n1;
      ov_b_q   <= sc_n2;
    end
  end

  // Normalisation: find the largest shift that keeps the halved sum at or above 2^31,
  // one power of two per stage. Numerators pass unchanged without overmodulation.
  logic        nm_vld_q [NORM_STAGES];
  logic        nm_ov_q  [NORM_STAGES];
  sector_t     nm_sec_q [NORM_STAGES];
  logic [63:0] nm_a_q   [NORM_STAGES];
  logic [63:0] nm_b_q   [NORM_STAGES];

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    logic        s_vld;
    logic        s_ov;
    sector_t     s_sec;
    logic [63:0] s_a;
    logic [63:0] s_b;
    logic [63:0] sh_a;
    logic [63:0] sh_b;
    logic        take;

    if (j == 0) begin : g_first
      assign s_vld = ov_vld_q;
      assign s_ov  = ov_q;
      assign s_sec = ov_sec_q;
      assign s_a   = ov_a_q;
      assign s_b   = ov_b_q;
    end else begin : g_next
      assign s_vld = nm_vld_q[j-1];
      assign s_ov  = nm_ov_q[j-1];
      assign s_sec = nm_sec_q[j-1];
      assign s_a   = nm_a_q[j-1];
      assign s_b   = nm_b_q[j-1];
    end

    assign sh_a = s_a >> (1 << (NORM_STAGES - 1 - j));
    assign sh_b = s_b >> (1 << (NORM_STAGES - 1 - j));
    assign take = s_ov && (({1'b0, sh_a} + {1'b0, sh_b}) >= 65'h8000_0000);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nm_vld_q[j] <= 1'b0;
      end else if (en) begin
        nm_vld_q[j] <= s_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        nm_ov_q[j]  <= s_ov;
        nm_sec_q[j] <= s_sec;
        nm_a_q[j]   <= take ? sh_a : s_a;
        nm_b_q[j]   <= take ? sh_b : s_b;
      end
    end
  end

  // Divider set-up: last halving, then dividend and divisor per lane.
  logic [63:0]      fa;
  logic [63:0]      fb;
  logic             last_sh;
  logic [DEN_W-1:0] vs_den;
  logic             pr_vld_q;
  logic             pr_ov_q;
  sector_t          pr_sec_q;
  logic [NUM_W-1:0] num1_q;
  logic [NUM_W-1:0] num2_q;
  logic [DEN_W-1:0] den1_q;
  logic [DEN_W-1:0] den2_q;

  assign last_sh = nm_ov_q[NORM_STAGES-1] &&
                   (({1'b0, nm_a_q[NORM_STAGES-1]} + {1'b0, nm_b_q[NORM_STAGES-1]})
                    >= 65'h8000_0000);
  assign fa      = last_sh ? (nm_a_q[NORM_STAGES-1] >> 1) : nm_a_q[NORM_STAGES-1];
  assign fb      = last_sh ? (nm_b_q[NORM_STAGES-1] >> 1) : nm_b_q[NORM_STAGES-1];
  assign vs_den  = {6'b0, vs, 10'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (en) begin
      pr_vld_q <= nm_vld_q[NORM_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_ov_q  <= nm_ov_q[NORM_STAGES-1];
      pr_sec_q <= nm_sec_q[NORM_STAGES-1];
      num1_q   <= nm_ov_q[NORM_STAGES-1] ? {fa[31:0], 32'b0} : fa;
      den1_q   <= nm_ov_q[NORM_STAGES-1] ? fa[31:0] + fb[31:0] : vs_den;
      num2_q   <= fb;
      den2_q   <= vs_den;
    end
  end

  // Two divider lanes with the control travelling alongside.
  logic [QUO_W-1:0] quo1;
  logic [QUO_W-1:0] quo2;
  logic             dv_vld_q [DIV_STAGES];
  logic             dv_ov_q  [DIV_STAGES];
  sector_t          dv_sec_q [DIV_STAGES];

  svpwm_div u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num1_q),
    .den_i (den1_q),
    .quo_o (quo1)
  );

  svpwm_div u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num2_q),
    .den_i (den2_q),
    .quo_o (quo2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_vld_q[0] <= pr_vld_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_ov_q[0]  <= pr_ov_q;
      dv_sec_q[0] <= pr_sec_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_ov_q[k]  <= dv_ov_q[k-1];
        dv_sec_q[k] <= dv_sec_q[k-1];
      end
    end
  end

  // Phase times: T1, T2, half of T0, combined per sector.
  logic        d_ov;
  sector_t     d_sec;
  logic [33:0] t1;
  logic [33:0] t2;
  logic [33:0] t0;
  logic [33:0] hf;
  logic [33:0] ta;
  logic [33:0] tb;
  logic [33:0] tc;
  logic        ts_vld_q;
  logic        ts_ov_q;
  sector_t     ts_sec_q;
  logic [33:0] ta_q;
  logic [33:0] tb_q;
  logic [33:0] tc_q;

  assign d_ov  = dv_ov_q[DIV_STAGES-1];
  assign d_sec = dv_sec_q[DIV_STAGES-1];
  assign t1    = 34'(quo1);
  assign t2    = d_ov ? (ONE_T - t1) : 34'(quo2);
  assign t0    = d_ov ? 34'd0 : (ONE_T - t1 - t2);
  assign hf    = t0 >> 1;

  always_comb begin
    case (d_sec)
      SEC_1: begin
        ta = t1 + t2 + hf;
        tb = t2 + hf;
        tc = hf;
      end
      SEC_2: begin
        ta = t1 + hf;
        tb = t1 + t2 + hf;
        tc = hf;
      end
      SEC_3: begin
        ta = hf;
        tb = t1 + t2 + hf;
        tc = t2 + hf;
      end
      SEC_4: begin
        ta = hf;
        tb = t1 + hf;
        tc = t1 + t2 + hf;
      end
      SEC_5: begin
        ta = t2 + hf;
        tb = hf;
        tc = t1 + t2 + hf;
      end
      default: begin
        ta = t1 + t2 + hf;
        tb = hf;
        tc = t1 + hf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_vld_q <= 1'b0;
    end else if (en) begin
      ts_vld_q <= dv_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_ov_q  <= d_ov;
      ts_sec_q <= d_sec;
      ta_q     <= ta;
      tb_q     <= tb;
      tc_q     <= tc;
    end
  end

  // Output register: rounded duties.
  logic [55:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ts_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {4'b0, ts_ov_q, ts_sec_q, to_duty(tc_q), to_duty(tb_q), to_duty(ta_q)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // The sector is always one to six.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[50:48] != 3'd0) && (m_axis_tdata[50:48] != 3'd7))
    else $error("sector out of range");

  // Under overmodulation the zero-vector time vanishes, so one phase duty is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[51]) |->
      (m_axis_tdata[15:0] == 16'd0) || (m_axis_tdata[31:16] == 16'd0) ||
      (m_axis_tdata[47:32] == 16'd0))
    else $error("overmodulated result without a zero phase");

  // A held result must not be overwritten by the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

// ===== sv/svpwm_cordic.sv =====
// Pipelined rotation of the d/q vector by the rotor angle, two iterations per stage.
`timescale 1ns / 1ps
module svpwm_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  svpwm_pkg::cordic_t  vec_i,
  input  logic [15:0]         ang_i,
  output logic                vld_o,
  output svpwm_pkg::cordic_t  vec_o,
  output logic [15:0]         ang_o
);
  import svpwm_pkg::*;

  cordic_t     st_q  [CORDIC_STAGES];
  logic        vld_q [CORDIC_STAGES];
  logic [15:0] ang_q [CORDIC_STAGES];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    cordic_t     src;
    cordic_t     nxt;
    logic        src_vld;
    logic [15:0] src_ang;

    if (s == 0) begin : g_first
      assign src     = vec_i;
      assign src_vld = vld_i;
      assign src_ang = ang_i;
    end else begin : g_next
      assign src     = st_q[s-1];
      assign src_vld = vld_q[s-1];
      assign src_ang = ang_q[s-1];
    end

    // Two micro-rotations, each steered by the sign of the residual angle.
    always_comb begin
      xy_t                   xv;
      xy_t                   yv;
      xy_t                   xo;
      logic signed [Z_W-1:0] zv;
      xv = src.x;
      yv = src.y;
      zv = src.z;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        xo = xv;
        if (!zv[Z_W-1]) begin
          xv = xv - (yv >>> (s * STEPS_PER_STAGE + j));
          yv = yv + (xo >>> (s * STEPS_PER_STAGE + j));
          zv = zv - ATAN_TURNS[s * STEPS_PER_STAGE + j];
        end else begin
          xv = xv + (yv >>> (s * STEPS_PER_STAGE + j));
          yv = yv - (xo >>> (s * STEPS_PER_STAGE + j));
          zv = zv + ATAN_TURNS[s * STEPS_PER_STAGE + j];
        end
      end
      nxt.x = xv;
      nxt.y = yv;
      nxt.z = zv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]  <= nxt;
        ang_q[s] <= src_ang;
      end
    end
  end

  assign vld_o = vld_q[CORDIC_STAGES-1];
  assign vec_o = st_q[CORDIC_STAGES-1];
  assign ang_o = ang_q[CORDIC_STAGES-1];

endmodule

// ===== sv/svpwm_sect.sv =====
// Sector detection and adjacent-vector time numerators, three register stages.
`timescale 1ns / 1ps
module svpwm_sect (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  svpwm_pkg::xy_t     x_i,
  input  svpwm_pkg::xy_t     y_i,
  input  logic [15:0]        ang_i,
  output logic               vld_o,
  output svpwm_pkg::sector_t sector_o,
  output logic [63:0]        n1_o,
  output logic [63:0]        n2_o
);
  import svpwm_pkg::*;

  // Sign of sqrt3 * x - y from signs and a magnitude comparison.
  function automatic logic signed [1:0] s3cmp(input logic xn, input logic xz, input logic yn,
                                               input logic yz, input logic signed [1:0] c);
    logic signed [1:0] r;
    if (!xn && (yn || yz)) begin
      r = (xz && yz) ? 2'sd0 : 2'sd1;
    end else if ((xn || xz) && !yn) begin
      r = -2'sd1;
    end else begin
      r = (!xn && !xz) ? c : -c;
    end
    return r;
  endfunction

  // Stage A: squares of the magnitudes and the coefficient products.
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic               a_vld_q;
  logic [63:0]        ax2_q;
  logic [63:0]        ay2_q;
  logic signed [63:0] ga_q;
  logic signed [63:0] ha_q;
  logic               xn_q, xz_q, yn_q, yz_q;
  logic [15:0]        ang_q;

  assign ax = x_i[XY_W-1] ? 32'(-x_i) : 32'(x_i);
  assign ay = y_i[XY_W-1] ? 32'(-y_i) : 32'(y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q <= {32'b0, ax} * {32'b0, ax};
      ay2_q <= {32'b0, ay} * {32'b0, ay};
      ga_q  <= y_i * COEF_G;
      ha_q  <= x_i * COEF_H;
      xn_q  <= x_i[XY_W-1];
      xz_q  <= (x_i == '0);
      yn_q  <= y_i[XY_W-1];
      yz_q  <= (y_i == '0);
      ang_q <= ang_i;
    end
  end

  // Stage B: exact sector boundary tests.
  logic [63:0]        l3;
  logic signed [1:0]  cmag;
  logic signed [1:0]  ca;
  logic signed [1:0]  cb;
  sector_t            sec_d;
  logic               b_vld_q;
  sector_t            sec_q;
  logic signed [63:0] gb_q;
  logic signed [63:0] hb_q;

  assign l3   = (ax2_q << 1) + ax2_q;
  assign cmag = (l3 > ay2_q) ? 2'sd1 : ((l3 < ay2_q) ? -2'sd1 : 2'sd0);
  assign ca   = s3cmp(xn_q, xz_q, yn_q, yz_q, cmag);
  assign cb   = s3cmp(xn_q, xz_q, !yn_q && !yz_q, yz_q, cmag);

  always_comb begin
    if (xz_q && yz_q) begin
      sec_d = 3'(({3'b0, ang_q} * 19'd6) >> ANGLE_BITS) + 3'd1;
    end else if ((!yn_q && !yz_q) || (yz_q && !xn_q)) begin
      if (ca == 2'sd1) begin
        sec_d = SEC_1;
      end else if (cb == 2'sd1) begin
        sec_d = SEC_2;
      end else begin
        sec_d = SEC_3;
      end
    end else begin
      if (ca == -2'sd1) begin
        sec_d = SEC_4;
      end else if (cb == -2'sd1) begin
        sec_d = SEC_5;
      end else begin
        sec_d = SEC_6;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q <= sec_d;
      gb_q  <= ga_q;
      hb_q  <= ha_q;
    end
  end

  // Stage C: numerators per sector, clamped at zero.
  logic signed [63:0] m1;
  logic signed [63:0] m2;
  logic               c_vld_q;
  sector_t            c_sec_q;
  logic [63:0]        n1_q;
  logic [63:0]        n2_q;

  always_comb begin
    case (sec_q)
      SEC_1: begin
        m1 = hb_q - gb_q;
        m2 = gb_q <<< 1;
      end
      SEC_2: begin
        m1 = gb_q + hb_q;
        m2 = gb_q - hb_q;
      end
      SEC_3: begin
        m1 = gb_q <<< 1;
        m2 = -gb_q - hb_q;
      end
      SEC_4: begin
        m1 = gb_q - hb_q;
        m2 = -(gb_q <<< 1);
      end
      SEC_5: begin
        m1 = -hb_q - gb_q;
        m2 = hb_q - gb_q;
      end
      default: begin
        m1 = -(gb_q <<< 1);
        m2 = hb_q + gb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_sec_q <= sec_q;
      n1_q    <= m1[63] ? 64'd0 : m1;
      n2_q    <= m2[63] ? 64'd0 : m2;
    end
  end

  assign vld_o    = c_vld_q;
  assign sector_o = c_sec_q;
  assign n1_o     = n1_q;
  assign n2_o     = n2_q;

endmodule

// ===== sv/svpwm_div.sv =====
// Restoring divider lane, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module svpwm_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [svpwm_pkg::NUM_W-1:0] num_i,
  input  logic [svpwm_pkg::DEN_W-1:0] den_i,
  output logic [svpwm_pkg::QUO_W-1:0] quo_o
);
  import svpwm_pkg::*;

  // The quotient is known to fit QUO_W bits, so the top bits seed the remainder.
  logic [QUO_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] num_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [QUO_W-1:0] rem_s;
    logic [QUO_W-1:0] num_s;
    logic [QUO_W-1:0] quo_s;
    logic [DEN_W-1:0] den_s;
    logic [QUO_W-1:0] tmp;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_s = QUO_W'(num_i[NUM_W-1:QUO_W]);
      assign num_s = num_i[QUO_W-1:0];
      assign quo_s = '0;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_q[s-1];
      assign num_s = num_q[s-1];
      assign quo_s = quo_q[s-1];
      assign den_s = den_q[s-1];
    end

    assign tmp = {rem_s[QUO_W-2:0], num_s[QUO_W-1]};
    assign ge  = (tmp >= QUO_W'(den_s));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? (tmp - QUO_W'(den_s)) : tmp;
        num_q[s] <= num_s << 1;
        quo_q[s] <= {quo_s[QUO_W-2:0], ge};
        den_q[s] <= den_s;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule
